/* sv/ffc_pkg.sv */
// Package for the flat-field correction block: pixel and result beat types
// and fixed constants. No dependencies.
package ffc_pkg;

    // ln(2) in Q26
    localparam logic [25:0] LN2_Q26 = 26'd46516320;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [15:0] proj_sample;
        logic [15:0] dark_sample;
        logic [15:0] flat_sample;
        logic        last_pixel;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] corrected;
        logic               invalid;
        logic               frame_end;
    } t_result;

endpackage

/* sv/flat_field_correction.sv */
// Flat-field correction: (P - D) / (F - D) or -ln of it, one pixel a cycle.
// Pipeline: input capture, differences, the core divide and log2 stages, the
// log difference, the ln 2 scaling and the output register.
// Throughput: one pixel every cycle, set by the one-bit-per-stage divider and
// the one-squaring-per-stage log2 pipeline; busy never rises.
// Reset (synchronous, active low) clears all valid bits and the mode register.
module flat_field_correction #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ffc_pkg::t_pixel   i_pixel,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_result_strobe,
    output ffc_pkg::t_result  o_result
);
    import ffc_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int IN_W = (SB < 16) ? SB : 16;
    localparam int QW   = SB + FB + 1;
    localparam int NS   = (QW > 32) ? QW : 32;
    localparam int EW   = $clog2(SB);
    localparam int DLW  = EW + 32;
    localparam int LOW  = DLW / 2;
    localparam int HIW  = DLW - LOW;
    localparam int PLW  = LOW + 26;
    localparam int PHW  = HIW + 26;
    localparam int PW   = DLW + 27;
    localparam int SH   = 58 - FB;
    localparam int LAT  = NS + 4;

    typedef struct packed {
        logic          v;
        logic          last;
        logic          mode;
        logic          bad;
        logic          neg;
        logic [SB-1:0] dvs;
        logic [SB-1:0] rem;
        logic [QW-1:0] divd;
        logic [QW-1:0] quo;
        logic [30:0]   md;
        logic [30:0]   mn;
        logic [31:0]   fd;
        logic [31:0]   fn;
        logic [EW-1:0] ed;
        logic [EW-1:0] en;
    } t_core;

    // saturate a magnitude with a sign into 32 bits
    function automatic logic [31:0] sat32(input logic [63:0] mag, input logic neg);
        logic [31:0] res;
        if (neg) begin
            if (mag > 64'(SAT_MIN)) res = SAT_MIN;
            else                    res = 32'(~mag + 64'd1);
        end else begin
            if (mag > 64'(SAT_MAX)) res = SAT_MAX;
            else                    res = mag[31:0];
        end
        return res;
    endfunction

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // hold the mode register
    logic r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // capture the input beat
    logic          r_v0, r_last0, r_mode0;
    logic [SB-1:0] r_p, r_d, r_f;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
        r_last0 <= i_pixel.last_pixel;
        r_mode0 <= r_mode;
        r_p     <= SB'(i_pixel.proj_sample[IN_W-1:0]);
        r_d     <= SB'(i_pixel.dark_sample[IN_W-1:0]);
        r_f     <= SB'(i_pixel.flat_sample[IN_W-1:0]);
    end

    // form differences, flags, dividend and normalised log mantissas
    t_core r_c [0:NS];
    t_core n_c0;
    always_comb begin
        logic [SB:0]   num, den;
        logic [SB-1:0] an;
        logic [EW-1:0] ed, en;
        logic [4:0]    shd, shn;
        num = {1'b0, r_p} - {1'b0, r_d};
        den = {1'b0, r_f} - {1'b0, r_d};
        an  = num[SB] ? SB'(-num) : num[SB-1:0];
        ed  = '0;
        en  = '0;
        for (int i = 0; i < SB; i++) begin
            if (den[i]) ed = EW'(i);
            if (an[i])  en = EW'(i);
        end
        shd = 5'd30 - 5'(ed);
        shn = 5'd30 - 5'(en);
        n_c0.v    = r_v0;
        n_c0.last = r_last0;
        n_c0.mode = r_mode0;
        n_c0.bad  = den[SB] || (den == '0) ||
                    (r_mode0 && (num[SB] || (num == '0)));
        n_c0.neg  = num[SB];
        n_c0.dvs  = den[SB-1:0];
        n_c0.rem  = '0;
        n_c0.divd = QW'({an, {FB{1'b0}}}) + QW'(den[SB-1:1]);
        n_c0.quo  = '0;
        n_c0.md   = 31'(den[SB-1:0]) << shd;
        n_c0.mn   = 31'(an) << shn;
        n_c0.fd   = '0;
        n_c0.fn   = '0;
        n_c0.ed   = ed;
        n_c0.en   = en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0].v <= 1'b0;
        end else begin
            r_c[0] <= n_c0;
        end
    end

    // core stages: up to one quotient and one log2 fraction bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_core
        t_core n_c;
        always_comb begin
            logic [SB:0]  t;
            logic [61:0]  sqd, sqn;
            logic [31:0]  sd, sn;
            t   = '0;
            n_c = r_c[k];
            if (k < QW) begin
                t = {r_c[k].rem, r_c[k].divd[QW-1]};
                n_c.divd = r_c[k].divd << 1;
                if (t >= {1'b0, r_c[k].dvs}) begin
                    n_c.rem = SB'(t - {1'b0, r_c[k].dvs});
                    n_c.quo = {r_c[k].quo[QW-2:0], 1'b1};
                end else begin
                    n_c.rem = t[SB-1:0];
                    n_c.quo = {r_c[k].quo[QW-2:0], 1'b0};
                end
            end
            sqd = 62'(r_c[k].md) * 62'(r_c[k].md);
            sqn = 62'(r_c[k].mn) * 62'(r_c[k].mn);
            sd  = sqd[61:30];
            sn  = sqn[61:30];
            if (k < 32) begin
                n_c.md = sd[31] ? sd[31:1] : sd[30:0];
                n_c.fd = {r_c[k].fd[30:0], sd[31]};
                n_c.mn = sn[31] ? sn[31:1] : sn[30:0];
                n_c.fn = {r_c[k].fn[30:0], sn[31]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[k+1].v <= 1'b0;
            end else begin
                r_c[k+1] <= n_c;
            end
        end
    end

    // take the log difference
    logic           r_v1, r_last1, r_mode1, r_bad1, r_neg1, r_lneg1;
    logic [QW-1:0]  r_quo1;
    logic [DLW-1:0] r_dl1;
    always_ff @(posedge i_clk) begin
        logic [DLW-1:0] ld, ln;
        ld = {r_c[NS].ed, r_c[NS].fd};
        ln = {r_c[NS].en, r_c[NS].fn};
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_c[NS].v;
        end
        r_last1 <= r_c[NS].last;
        r_mode1 <= r_c[NS].mode;
        r_bad1  <= r_c[NS].bad;
        r_neg1  <= r_c[NS].neg;
        r_quo1  <= r_c[NS].quo;
        r_lneg1 <= ln > ld;
        r_dl1   <= (ln > ld) ? ln - ld : ld - ln;
    end

    // scale by ln 2 as two partial products
    logic           r_v2, r_last2, r_mode2, r_bad2, r_neg2, r_lneg2;
    logic [QW-1:0]  r_quo2;
    logic [PLW-1:0] r_plo;
    logic [PHW-1:0] r_phi;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_last2 <= r_last1;
        r_mode2 <= r_mode1;
        r_bad2  <= r_bad1;
        r_neg2  <= r_neg1;
        r_lneg2 <= r_lneg1;
        r_quo2  <= r_quo1;
        r_plo   <= PLW'(r_dl1[LOW-1:0]) * PLW'(LN2_Q26);
        r_phi   <= PHW'(r_dl1[DLW-1:LOW]) * PHW'(LN2_Q26);
    end

    // sum, round, saturate and drive the result beat
    logic            r_strobe;
    t_result         r_res;
    always_ff @(posedge i_clk) begin
        logic [PW-1:0] prod;
        logic [31:0]   val;
        prod = (PW'(r_phi) << LOW) + PW'(r_plo) + (PW'(1) << (SH - 1));
        if (r_bad2)       val = '0;
        else if (r_mode2) val = sat32(64'(prod >> SH), r_lneg2);
        else              val = sat32(64'(r_quo2), r_neg2);
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v2;
        end
        r_res.corrected <= val;
        r_res.invalid   <= r_bad2;
        r_res.frame_end <= r_last2;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;

    // every result beat matches a pixel accepted earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(accept, LAT + 1))
        else $error("result beat without matching pixel");

    // an invalid result carries zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.invalid) |-> (o_result.corrected == 32'sd0))
        else $error("invalid result with nonzero value");

    // an accepted pixel always yields a result beat
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && $past(i_rst_n, LAT)) |-> ##(LAT + 1) (o_result_strobe || !i_rst_n))
        else $error("pixel lost in pipeline");

endmodule

/* tb/flat_field_correction_tb.sv */
// Testbench for flat_field_correction: directed table then random pixels,
// each result checked against a local predictor. Depends on ffc_pkg and flat_field_correction.
`timescale 1ns / 1ps

module flat_field_correction_tb;
    import ffc_pkg::*;

    localparam int LATENCY  = 37;
    localparam int WATCHDOG = 2000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    t_pixel  pixel;
    logic    cfg_we;
    logic    cfg_wdata;
    logic    res_strobe;
    t_result res;

    // predictor state and the store of pending corrections
    logic    mode_q;
    t_result pending_q[$];
    int      mismatches;
    int      orphans;
    int      idle_cycles;

    typedef struct {
        logic [15:0] p;
        logic [15:0] d;
        logic [15:0] f;
        logic        last;
        bit          known;
        logic [31:0] val;
        logic        bad;
    } t_row;

    flat_field_correction i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_pixel         (pixel),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_result_strobe (res_strobe),
        .o_result        (res)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // log2 of x in Q32 by repeated squaring
    function automatic logic [63:0] log2_fix(logic [31:0] x);
        int unsigned top;
        logic [63:0] m;
        logic [63:0] fr;
        top = 0;
        fr  = '0;
        for (int i = 0; i < 32; i++) if (x[i]) top = i;
        m = 64'(x) << (30 - top);
        for (int i = 0; i < 32; i++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000) begin
                m     = m >> 1;
                fr[0] = 1'b1;
            end
        end
        return (64'(top) << 32) | fr;
    endfunction

    function automatic logic [31:0] sign_sat(logic [63:0] mag, bit neg);
        if (neg) begin
            if (mag > 64'h8000_0000) return SAT_MIN;
            return 32'(-mag);
        end
        if (mag > 64'h7fff_ffff) return SAT_MAX;
        return mag[31:0];
    endfunction

    function automatic t_result correct_pixel(t_pixel px, logic absorb);
        t_result     r;
        longint      num;
        longint      den;
        logic [63:0] ln_d;
        logic [63:0] ln_n;
        logic [63:0] dl;
        logic [63:0] mag;
        bit          neg;
        num = longint'(px.proj_sample) - longint'(px.dark_sample);
        den = longint'(px.flat_sample) - longint'(px.dark_sample);
        r.corrected = '0;
        r.invalid   = 1'b0;
        r.frame_end = px.last_pixel;
        if (den <= 0) begin
            r.invalid = 1'b1;
        end else if (absorb) begin
            if (num <= 0) begin
                r.invalid = 1'b1;
            end else begin
                ln_d = log2_fix(32'(den));
                ln_n = log2_fix(32'(num));
                neg  = ln_n > ln_d;
                dl   = neg ? ln_n - ln_d : ln_d - ln_n;
                mag  = (dl * 64'(LN2_Q26) + (64'd1 << 41)) >> 42;
                r.corrected = sign_sat(mag, neg);
            end
        end else begin
            neg = num < 0;
            mag = 64'(neg ? -num : num);
            mag = ((mag << 16) + 64'(den) / 2) / 64'(den);
            r.corrected = sign_sat(mag, neg);
        end
        return r;
    endfunction

    // check every strobed beat against the oldest expectation
    always @(posedge clk) begin
        t_result want;
        if (res_strobe) begin
            if (pending_q.size() == 0) begin
                orphans++;
                if (mismatches + orphans <= 10) $display("unexpected result %h", res);
            end else begin
                want = pending_q.pop_front();
                if (want !== res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val %h inv %b end %b, got val %h inv %b end %b",
                                 want.corrected, want.invalid, want.frame_end,
                                 res.corrected, res.invalid, res.frame_end);
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk) begin
        if ((start && !busy) || res_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drop start only when a random gap is drawn
    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // hold one pixel until accepted; start stays high into the next beat
    task automatic send_pixel(t_pixel px, bit gap);
        if (gap) random_gap();
        start <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_q.push_back(correct_pixel(px, mode_q));
        @(negedge clk);
    endtask

    task automatic drain_and_set(logic absorb);
        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= absorb;
        @(negedge clk);
        cfg_we <= 1'b0;
        mode_q = absorb;
    endtask

    function automatic logic [15:0] rand_sample(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15));
            2: return 16'($urandom_range(65520, 65535));
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    initial begin
        t_row   rows[$];
        t_pixel px;
        t_result want;
        logic   absorb;
        int     kind;

        rst_n = 1'b0; start = 1'b0; pixel = '0; cfg_we = 1'b0; cfg_wdata = 1'b0;
        mode_q = 1'b0; mismatches = 0; orphans = 0; idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table: p, d, f, last, known, expected value, invalid
        rows.push_back('{16'd0, 16'd0, 16'd0, 1'b0, 1, 32'h0, 1'b1});
        rows.push_back('{16'd5, 16'd9, 16'd9, 1'b1, 1, 32'h0, 1'b1});
        rows.push_back('{16'd5, 16'd9, 16'd3, 1'b0, 1, 32'h0, 1'b1});
        rows.push_back('{16'd100, 16'd0, 16'd100, 1'b0, 1, 32'h0001_0000, 1'b0});
        rows.push_back('{16'd0, 16'd0, 16'd1, 1'b0, 1, 32'h0, 1'b0});
        rows.push_back('{16'hffff, 16'd0, 16'd1, 1'b1, 1, 32'h7fff_ffff, 1'b0});
        rows.push_back('{16'd0, 16'hfffe, 16'hffff, 1'b0, 1, 32'h8000_0000, 1'b0});
        rows.push_back('{16'd1, 16'd0, 16'd3, 1'b0, 0, 32'h0, 1'b0});
        rows.push_back('{16'd2, 16'd0, 16'd3, 1'b0, 0, 32'h0, 1'b0});
        rows.push_back('{16'hffff, 16'hffff, 16'hffff, 1'b1, 1, 32'h0, 1'b1});
        rows.push_back('{16'd1, 16'd0, 16'hffff, 1'b0, 0, 32'h0, 1'b0});
        rows.push_back('{16'd7, 16'd3, 16'd11, 1'b0, 0, 32'h0, 1'b0});

        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) drain_and_set(1'b1);
            foreach (rows[i]) begin
                px = '{rows[i].p, rows[i].d, rows[i].f, rows[i].last};
                // typed-in values hold for ratio mode, and for bad denominators always
                if (rows[i].known && (pass == 0 || rows[i].bad)) begin
                    want = correct_pixel(px, mode_q);
                    if (want.corrected !== rows[i].val || want.invalid !== rows[i].bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row %0d: exp %h/%b, predictor %h/%b", i,
                                     rows[i].val, rows[i].bad, want.corrected, want.invalid);
                    end
                end
                send_pixel(px, 1'($urandom_range(0, 1)));
            end
        end

        // random phases alternating the mode, long stretches unbroken
        absorb = 1'b0;
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(absorb);
            for (int n = 0; n < 220; n++) begin
                kind = $urandom_range(0, 9);
                px.dark_sample = rand_sample($urandom_range(0, 3));
                if (kind < 7) begin
                    // mostly well-formed: flat above dark, projection around
                    px.flat_sample = px.dark_sample
                                     + 16'($urandom_range(1, 65535 - px.dark_sample + 1));
                    if (px.flat_sample <= px.dark_sample)
                        px.flat_sample = px.dark_sample + 16'd1;
                    if (px.dark_sample == 16'hffff) px.dark_sample = 16'hfffe;
                    px.proj_sample = rand_sample($urandom_range(0, 3));
                end else begin
                    px.flat_sample = rand_sample($urandom_range(0, 3));
                    px.proj_sample = rand_sample($urandom_range(0, 3));
                end
                px.last_pixel = ($urandom_range(0, 15) == 0);
                send_pixel(px, (ph % 3 != 2) && $urandom_range(0, 1));
            end
            absorb = ~absorb;
        end

        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        if (mismatches == 0 && orphans == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
